### hw/rtl/nul_free_varint_encoder_top_defines.svh
// Assertion macros shared by the encoder RTL.
`ifndef NUL_FREE_VARINT_ENCODER_TOP_DEFINES_SVH
`define NUL_FREE_VARINT_ENCODER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define NFV_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("nfv check failed");

// Next-cycle implication.
`define NFV_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("nfv check failed");

`endif

### hw/rtl/nfv_pkg.sv
// Shared types and constants of the NUL-free varint encoder.
package nfv_pkg;

    // Form codes: number of code bytes minus two
    localparam logic [1:0] FORM_2B = 2'd0;
    localparam logic [1:0] FORM_3B = 2'd1;
    localparam logic [1:0] FORM_4B = 2'd2;
    localparam logic [1:0] FORM_5B = 2'd3;

    localparam int DIGIT_STAGES = 4;

    // Lower bounds of each form (cumulative biases)
    localparam logic [31:0] ONE_BYTE_LIMIT = 32'd127;
    localparam logic [31:0] BASE_3B        = 32'd16447;
    localparam logic [31:0] BASE_4B        = 32'd2097247;
    localparam logic [31:0] BASE_5B        = 32'd267399247;

    // floor(x / 255) == (x * RECIP_255) >> 39 for every 32-bit x
    localparam logic [31:0] RECIP_255  = 32'h8080_8081;
    localparam int          RECIP_SHIFT = 39;

    // Unary length prefix of the lead byte
    function automatic logic [7:0] lead_prefix(input logic [1:0] form);
        logic [7:0] p;
        unique case (form)
            FORM_2B: p = 8'h80;
            FORM_3B: p = 8'hC0;
            FORM_4B: p = 8'hE0;
            FORM_5B: p = 8'hF0;
            default: p = 8'h80;
        endcase
        return p;
    endfunction

    // Item in flight through the pipeline
    typedef struct packed {
        logic [31:0]     rem;        // value still to be split into digits
        logic [1:0]      form;
        logic            one_byte;
        logic [7:0]      small_byte; // code byte of the one-byte form
        logic [3:0][7:0] digit;      // trailing bytes, digit[0] least significant
    } nfv_item_t;

endpackage

### hw/rtl/nfv_classify.sv
// Two pipeline stages: range compares, then bias subtraction.
module nfv_classify
    import nfv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] in_value,
    output logic        out_valid,
    input  logic        out_ready,
    output nfv_item_t   out_item
);

    logic        s1_valid_reg, s1_valid_next;
    logic [31:0] s1_value_reg;
    logic [3:0]  s1_below_reg;   // value below 127 / 3B base / 4B base / 5B base
    logic        s1_ready;
    logic        s2_valid_reg, s2_valid_next;
    nfv_item_t   s2_item_reg, s2_item_next;
    logic        s2_ready;

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // Stage 1: parallel range compares
    assign s1_valid_next = in_valid ? 1'b1 : (s1_valid_reg && !s2_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_ready) begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready && in_valid) begin
            s1_value_reg <= in_value;
            s1_below_reg <= {in_value < BASE_5B, in_value < BASE_4B,
                             in_value < BASE_3B, in_value < ONE_BYTE_LIMIT};
        end
    end

    // Stage 2: pick the form and remove its bias
    always_comb begin
        s2_item_next            = '0;
        s2_item_next.small_byte = s1_value_reg[7:0] + 8'd1;
        if (s1_below_reg[0]) begin
            s2_item_next.one_byte = 1'b1;
        end else if (s1_below_reg[1]) begin
            s2_item_next.form = FORM_2B;
            s2_item_next.rem  = s1_value_reg - ONE_BYTE_LIMIT;
        end else if (s1_below_reg[2]) begin
            s2_item_next.form = FORM_3B;
            s2_item_next.rem  = s1_value_reg - BASE_3B;
        end else if (s1_below_reg[3]) begin
            s2_item_next.form = FORM_4B;
            s2_item_next.rem  = s1_value_reg - BASE_4B;
        end else begin
            s2_item_next.form = FORM_5B;
            s2_item_next.rem  = s1_value_reg - BASE_5B;
        end
    end

    assign s2_valid_next = s1_valid_reg ? 1'b1 : (s2_valid_reg && !out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_ready) begin
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_ready && s1_valid_reg) begin
            s2_item_reg <= s2_item_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_item  = s2_item_reg;

endmodule

### hw/rtl/nfv_digit.sv
// One base-255 digit stage: divide by 255 through a reciprocal multiply.
module nfv_digit
    import nfv_pkg::*;
#(
    parameter int STAGE_IDX = 0
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  nfv_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output nfv_item_t out_item
);

    logic        valid_reg, valid_next;
    nfv_item_t   item_reg, item_next;
    logic [63:0] prod;
    logic [31:0] quot;
    logic [31:0] rmd;

    assign in_ready = !valid_reg || out_ready;

    // Quotient and remainder; forms shorter than this digit pass unchanged
    always_comb begin
        prod      = {32'd0, in_item.rem} * {32'd0, RECIP_255};
        quot      = {7'd0, prod[63:RECIP_SHIFT]};
        rmd       = in_item.rem - {quot[23:0], 8'd0} + quot;
        item_next = in_item;
        if (!in_item.one_byte && (in_item.form >= 2'(STAGE_IDX))) begin
            item_next.rem              = quot;
            item_next.digit[STAGE_IDX] = rmd[7:0] + 8'd1;
        end
    end

    assign valid_next = in_valid ? 1'b1 : (valid_reg && !out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

### hw/rtl/nfv_serializer.sv
// Output stage: builds the code bytes and sends them one beat at a time.
`include "nul_free_varint_encoder_top_defines.svh"
module nfv_serializer
    import nfv_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  nfv_item_t  in_item,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    logic [4:0][7:0] sh_reg, sh_next;
    logic [2:0]      cnt_reg, cnt_next;   // bytes left of the current code
    logic [7:0]      lead;
    logic            load;
    logic            pop;

    assign m_tvalid = (cnt_reg != 3'd0);
    assign m_tlast  = (cnt_reg == 3'd1);
    assign m_tdata  = sh_reg[0];
    assign pop      = m_tvalid && m_tready;
    assign in_ready = !m_tvalid || (m_tready && m_tlast);
    assign load     = in_valid && in_ready;

    // Lead byte: length prefix over the top quotient
    assign lead = lead_prefix(in_item.form) | in_item.rem[7:0];

    always_comb begin
        sh_next  = sh_reg;
        cnt_next = cnt_reg;
        if (load) begin
            sh_next = '0;
            if (in_item.one_byte) begin
                sh_next[0] = in_item.small_byte;
                cnt_next   = 3'd1;
            end else begin
                sh_next[0] = lead;
                cnt_next   = {1'b0, in_item.form} + 3'd2;
                unique case (in_item.form)
                    FORM_2B: begin
                        sh_next[1] = in_item.digit[0];
                    end
                    FORM_3B: begin
                        sh_next[1] = in_item.digit[1];
                        sh_next[2] = in_item.digit[0];
                    end
                    FORM_4B: begin
                        sh_next[1] = in_item.digit[2];
                        sh_next[2] = in_item.digit[1];
                        sh_next[3] = in_item.digit[0];
                    end
                    FORM_5B: begin
                        sh_next[1] = in_item.digit[3];
                        sh_next[2] = in_item.digit[2];
                        sh_next[3] = in_item.digit[1];
                        sh_next[4] = in_item.digit[0];
                    end
                    default: begin
                        sh_next[1] = in_item.digit[0];
                    end
                endcase
            end
        end else if (pop) begin
            sh_next  = {8'd0, sh_reg[4:1]};
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 3'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        sh_reg <= sh_next;
    end

    // Checks
    `NFV_ASSERT_IMPL(a_no_nul_byte, aclk, aresetn, m_tvalid, m_tdata != 8'd0)
    `NFV_ASSERT_IMPL(a_cnt_range, aclk, aresetn, 1'b1, cnt_reg <= 3'd5)
    `NFV_ASSERT_IMPL(a_load_only_at_end, aclk, aresetn, load && m_tvalid, pop && m_tlast)
    `NFV_ASSERT_NEXT(a_pop_counts_down, aclk, aresetn, pop && !m_tlast && !load,
                     cnt_reg == $past(cnt_reg) - 3'd1)

endmodule

### hw/rtl/nul_free_varint_encoder_top.sv
// NUL-free varint encoder: 32-bit value in, 1 to 5 nonzero code bytes out.
// A value beat can be taken every cycle while the pipeline has room; each value
// becomes a code of N bytes (N = 1 below 127, then 2, 3, 4 or 5 by range), sent
// lead byte first with m_tlast on its final byte. The byte-wide output register
// sends one byte per cycle while m_tready is high and takes the next value as the
// last byte of the current code is accepted. A value passes two classify stages,
// four base-255 digit stages (one reciprocal multiply each) and the output
// register. No state is kept between values.
module nul_free_varint_encoder_top
    import nfv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] value_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] code_byte
    output logic        m_tlast     // last_byte
);

    logic      pipe_valid [DIGIT_STAGES+1];
    logic      pipe_ready [DIGIT_STAGES+1];
    nfv_item_t pipe_item  [DIGIT_STAGES+1];

    // Range classification and bias removal
    nfv_classify u_classify (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_value  (s_tdata),
        .out_valid (pipe_valid[0]),
        .out_ready (pipe_ready[0]),
        .out_item  (pipe_item[0])
    );

    // Digit extraction, least significant digit first
    for (genvar k = 0; k < DIGIT_STAGES; k++) begin : g_digit
        nfv_digit #(
            .STAGE_IDX (k)
        ) u_digit (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (pipe_valid[k]),
            .in_ready  (pipe_ready[k]),
            .in_item   (pipe_item[k]),
            .out_valid (pipe_valid[k+1]),
            .out_ready (pipe_ready[k+1]),
            .out_item  (pipe_item[k+1])
        );
    end

    // Byte serializer and output register
    nfv_serializer u_serializer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (pipe_valid[DIGIT_STAGES]),
        .in_ready (pipe_ready[DIGIT_STAGES]),
        .in_item  (pipe_item[DIGIT_STAGES]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
